// File: sv/tsd_pkg.sv
// Shared types and codes for the text splitter core.
// No dependencies; used by text_split_on_delimiter_core.
package tsd_pkg;

   // register indexes on the csr write port
   localparam logic CSR_DELIMITER_BYTES  = 1'b0;
   localparam logic CSR_DELIMITER_LENGTH = 1'b1;

   localparam logic [63:0] DELIMITER_BYTES_RESET  = 64'd44;
   localparam logic [3:0]  DELIMITER_LENGTH_RESET = 4'd1;

   // one piece descriptor as it waits in the result queue
   typedef struct packed {
      logic [15:0] piece_start;
      logic [15:0] piece_length;
      logic        last_piece;
      logic        no_pieces;
      logic        too_long;
   } piece_type;

endpackage

// File: sv/text_split_on_delimiter_core.sv
// Text splitter core: one text byte per word in, piece descriptors out.
// Depends on tsd_pkg (piece_type, csr indexes, register reset values).
//
// The core takes one text byte per cycle while the result queue has room, and
// compares the newest bytes against the delimiter in parallel. Each byte makes at most
// two descriptors (a delimiter match on the last byte gives the piece before it
// and then an empty tail); they go into a four-word result queue, and a new
// byte is taken whenever the queue has room for two, so one descriptor per byte
// flows at full rate while the output does not stall; two-descriptor bytes can fill the queue and hold the input.
// Configuration writes take effect at once and are meant only while idle.
module text_split_on_delimiter_core #(
   parameter int MAX_DELIMITER = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // [0] empty_text
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] piece_start, [31:16] piece_length
   output logic        rsp_tlast,   // last_piece
   output logic [1:0]  rsp_tuser,   // [0] no_pieces, [1] too_long
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int QDEPTH = 4;
   localparam int OUTW   = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic [POSITION_BITS-1:0] TEXT_LIMIT = '1;
   localparam logic [3:0] MAX_DL = 4'(MAX_DELIMITER);

   logic [63:0] delim_bytes_ff;
   logic [3:0]  delim_len_ff;

   logic [7:0]  recent_ff [MAX_DELIMITER];
   logic [7:0]  recent_in [MAX_DELIMITER];
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] cps_ff, cps_in;
   logic        ovf_ff, ovf_in;

   tsd_pkg::piece_type q_ff [QDEPTH];
   tsd_pkg::piece_type q_in [QDEPTH];
   logic [2:0]  cnt_ff, cnt_in;

   logic        accept, pop;
   logic [2:0]  base;
   logic        push0, push1;
   tsd_pkg::piece_type res0, res1;

   logic [3:0]  dl;
   logic [7:0]  win [MAX_DELIMITER];
   logic        win_hit;
   logic [POSITION_BITS-1:0] newpos, diff, mlen;
   logic        match;
   logic [OUTW-1:0] ext_start, ext_len, ext_tstart, ext_tlen;

   assign req_tready = (cnt_ff <= 3'(QDEPTH - 2));
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {q_ff[0].piece_length, q_ff[0].piece_start};
   assign rsp_tlast  = q_ff[0].last_piece;
   assign rsp_tuser  = {q_ff[0].too_long, q_ff[0].no_pieces};

   // window compare for each possible delimiter length; the hit for the set length is kept
   always_comb begin
      logic ok;
      dl = (delim_len_ff > MAX_DL) ? MAX_DL : delim_len_ff;
      win[0] = req_tdata;
      for (int k = 1; k < MAX_DELIMITER; k++) begin
         win[k] = recent_ff[k-1];
      end
      win_hit = 1'b0;
      for (int l = 1; l <= MAX_DELIMITER; l++) begin
         ok = 1'b1;
         for (int j = 0; j < l; j++) begin
            if (win[l-1-j] != delim_bytes_ff[8*j +: 8]) begin
               ok = 1'b0;
            end
         end
         if (dl == 4'(l)) begin
            win_hit = ok;
         end
      end
   end

   always_comb begin
      newpos = pos_ff + POSITION_BITS'(1);
      diff   = newpos - POSITION_BITS'(dl);
      mlen   = diff - cps_ff;
      match  = (dl != 4'd0) && (newpos >= POSITION_BITS'(dl)) &&
               (diff >= cps_ff) && win_hit;
   end

   // per-byte state update and result generation
   always_comb begin
      recent_in = recent_ff;
      pos_in    = pos_ff;
      cps_in    = cps_ff;
      ovf_in    = ovf_ff;
      push0     = 1'b0;
      push1     = 1'b0;
      res0      = '0;
      res1      = '0;
      ext_start = OUTW'(cps_ff);
      ext_len   = OUTW'(mlen);
      ext_tstart = '0;
      ext_tlen   = '0;
      if (accept) begin
         if (req_tuser) begin
            pos_in = '0;
            cps_in = '0;
            ovf_in = 1'b0;
            push0  = 1'b1;
            res0.last_piece = 1'b1;
            res0.no_pieces  = 1'b1;
         end else begin
            if (pos_ff != TEXT_LIMIT) begin
               recent_in = win;
               pos_in    = newpos;
               if (match) begin
                  push0 = 1'b1;
                  res0.piece_start  = ext_start[15:0];
                  res0.piece_length = ext_len[15:0];
                  res0.too_long     = ovf_ff;
                  cps_in = newpos;
               end
            end else begin
               ovf_in = 1'b1;
            end
            if (req_tlast) begin
               ext_tstart = OUTW'(cps_in);
               ext_tlen   = OUTW'(pos_in - cps_in);
               if (push0) begin
                  push1 = 1'b1;
                  res1.piece_start  = ext_tstart[15:0];
                  res1.piece_length = ext_tlen[15:0];
                  res1.last_piece   = 1'b1;
                  res1.too_long     = ovf_in;
               end else begin
                  push0 = 1'b1;
                  res0.piece_start  = ext_tstart[15:0];
                  res0.piece_length = ext_tlen[15:0];
                  res0.last_piece   = 1'b1;
                  res0.too_long     = ovf_in;
               end
               pos_in = '0;
               cps_in = '0;
               ovf_in = 1'b0;
            end
         end
      end
   end

   // result queue: head at slot 0, shifts down on pop, appends after survivors
   always_comb begin
      base = cnt_ff - {2'b00, pop};
      for (int i = 0; i < QDEPTH; i++) begin
         if (pop && i < QDEPTH - 1) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (push0 && base == 3'(i)) begin
            q_in[i] = res0;
         end
         if (push1 && (base + 3'd1) == 3'(i)) begin
            q_in[i] = res1;
         end
      end
      cnt_in = base + {2'b00, push0} + {2'b00, push1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_bytes_ff <= tsd_pkg::DELIMITER_BYTES_RESET;
         delim_len_ff   <= tsd_pkg::DELIMITER_LENGTH_RESET;
         pos_ff <= '0;
         cps_ff <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tsd_pkg::CSR_DELIMITER_BYTES:  delim_bytes_ff <= csr_wdata;
               tsd_pkg::CSR_DELIMITER_LENGTH: delim_len_ff   <= csr_wdata[3:0];
               default: ;
            endcase
         end
         pos_ff <= pos_in;
         cps_ff <= cps_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
      q_ff      <= q_in;
   end

endmodule
